// File: design/lss_pkg.sv
// light seek steering: shared constants, codes and types
// used by lss_step and light_seek_steering_core; depends on nothing
package lss_pkg;

  localparam int LUX_BITS     = 17;
  localparam int TIMEOUT_BITS = 16;
  localparam int PCT_BITS     = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // payload bits filled to whole bytes
  localparam int S_TDATA_BITS = ((2 * LUX_BITS + 2 + 7) / 8) * 8;
  localparam int S_TUSER_BITS = 3;
  localparam int M_TDATA_BITS = 16;  // 12 payload bits filled to whole bytes

  // item modes
  localparam logic [2:0] MODE_SAMPLE     = 3'd0;
  localparam logic [2:0] MODE_GRAD_TICK  = 3'd1;
  localparam logic [2:0] MODE_DECIDE     = 3'd2;
  localparam logic [2:0] MODE_MS_TICK    = 3'd3;
  localparam logic [2:0] MODE_GRAD_RESET = 3'd4;

  // drive actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_FORWARD  = 3'd1;
  localparam logic [2:0] ACT_LEFT     = 3'd2;
  localparam logic [2:0] ACT_RIGHT    = 3'd3;
  localparam logic [2:0] ACT_TURN_180 = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MID_PCT      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRONG_PCT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRADIENT_PCT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_MS   = 3'd4;

  // differential speed fractions, q0.8
  localparam logic [7:0] FRAC_LOW  = 8'd154;  // 0.6
  localparam logic [7:0] FRAC_HIGH = 8'd230;  // 0.9

  typedef struct packed {
    logic                enable;
    logic [PCT_BITS-1:0] mid_pct;
    logic [PCT_BITS-1:0] strong_pct;
    logic [PCT_BITS-1:0] gradient_pct;
    logic [15:0]         timeout_ms;
  } lss_cfg_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [LUX_BITS-1:0] lux_left;
    logic [LUX_BITS-1:0] lux_right;
    logic                dark_mode;
    logic                angle_reached;
  } lss_item_t;

  typedef struct packed {
    logic [LUX_BITS:0]       lux_difference;  // two's complement
    logic [LUX_BITS-1:0]     lux_mean;
    logic [LUX_BITS-1:0]     mid_threshold;
    logic [LUX_BITS-1:0]     strong_threshold;
    logic [LUX_BITS-1:0]     mean_earlier;
    logic [LUX_BITS-1:0]     mean_later;
    logic [LUX_BITS:0]       gradient;        // two's complement
    logic [LUX_BITS-1:0]     gradient_threshold;
    logic                    turn_flag;
    logic [TIMEOUT_BITS-1:0] timeout_left;
  } lss_state_t;

  typedef struct packed {
    logic       turning;
    logic [7:0] diff_fraction_q8;
    logic [2:0] action;
  } lss_result_t;

endpackage

// File: design/lss_step.sv
// light seek steering: next state and result for one item
// combinational; depends on lss_pkg
module lss_step (
  input  lss_pkg::lss_cfg_t    cfg,
  input  lss_pkg::lss_item_t   item,
  input  lss_pkg::lss_state_t  st,
  output lss_pkg::lss_state_t  st_next,
  output lss_pkg::lss_result_t res
);
  import lss_pkg::*;

  logic [LUX_BITS:0]            sum_lr;
  logic [LUX_BITS-1:0]          mean_new;
  logic [LUX_BITS+PCT_BITS-1:0] mid_prod;
  logic [LUX_BITS+PCT_BITS-1:0] strong_prod;
  logic [LUX_BITS:0]            sum_hist;
  logic [LUX_BITS-1:0]          grad_base;
  logic [LUX_BITS+PCT_BITS-1:0] grad_prod;
  logic [LUX_BITS-1:0]          grad_thr;
  logic [LUX_BITS:0]            abs_diff;
  logic [LUX_BITS:0]            abs_grad;
  logic                         light_mode;
  logic                         trip_mid;
  logic                         trip_strong;
  logic                         grad_pos;
  logic                         grad_neg;
  logic                         trigger;
  logic                         turn_now;
  logic [TIMEOUT_BITS-1:0]      tmo_now;
  logic                         diff_pos;

  // sample arithmetic
  assign sum_lr      = {1'b0, item.lux_left} + {1'b0, item.lux_right};
  assign mean_new    = sum_lr[LUX_BITS:1];
  assign mid_prod    = mean_new * cfg.mid_pct;
  assign strong_prod = mean_new * cfg.strong_pct;

  // one gradient threshold multiplier, shared by the tick, the reset and the decide clear
  assign sum_hist  = {1'b0, st.mean_later} + {1'b0, st.lux_mean};
  assign grad_base = (item.mode == MODE_GRAD_TICK) ? sum_hist[LUX_BITS:1] : st.lux_mean;
  assign grad_prod = grad_base * cfg.gradient_pct;
  assign grad_thr  = grad_prod[LUX_BITS+PCT_BITS-1:PCT_BITS];

  // decide terms
  assign abs_diff    = st.lux_difference[LUX_BITS] ? (~st.lux_difference + 1'b1)
                                                   : st.lux_difference;
  assign abs_grad    = st.gradient[LUX_BITS] ? (~st.gradient + 1'b1) : st.gradient;
  assign light_mode  = ~item.dark_mode;
  assign trip_mid    = abs_diff >= {1'b0, st.mid_threshold};
  assign trip_strong = abs_diff >= {1'b0, st.strong_threshold};
  assign grad_neg    = st.gradient[LUX_BITS];
  assign grad_pos    = ~st.gradient[LUX_BITS] && (st.gradient != '0);
  assign trigger     = (abs_grad >= {1'b0, st.gradient_threshold}) &&
                       ((grad_pos && light_mode) || (grad_neg && !light_mode));
  assign turn_now    = trigger || st.turn_flag;
  assign tmo_now     = trigger ? TIMEOUT_BITS'(cfg.timeout_ms) : st.timeout_left;
  assign diff_pos    = ~st.lux_difference[LUX_BITS] && (st.lux_difference != '0);

  always_comb begin
    st_next              = st;
    res.action           = ACT_NONE;
    res.diff_fraction_q8 = '0;
    if (cfg.enable) begin
      unique case (item.mode)
        MODE_SAMPLE: begin
          st_next.lux_difference   = {1'b0, item.lux_left} - {1'b0, item.lux_right};
          st_next.lux_mean         = mean_new;
          st_next.mid_threshold    = mid_prod[LUX_BITS+PCT_BITS-1:PCT_BITS];
          st_next.strong_threshold = strong_prod[LUX_BITS+PCT_BITS-1:PCT_BITS];
        end
        MODE_GRAD_TICK: begin
          st_next.mean_earlier       = st.mean_later;
          st_next.mean_later         = st.lux_mean;
          st_next.gradient           = {1'b0, st.lux_mean} - {1'b0, st.mean_later};
          st_next.gradient_threshold = grad_thr;
        end
        MODE_MS_TICK: begin
          if (st.timeout_left != '0) begin
            st_next.timeout_left = st.timeout_left - 1'b1;
          end
        end
        MODE_GRAD_RESET: begin
          st_next.turn_flag          = 1'b0;
          st_next.mean_earlier       = st.lux_mean;
          st_next.mean_later         = st.lux_mean;
          st_next.gradient           = '0;
          st_next.gradient_threshold = grad_thr;
        end
        MODE_DECIDE: begin
          if (trigger) begin
            st_next.mean_earlier       = st.lux_mean;
            st_next.mean_later         = st.lux_mean;
            st_next.gradient           = '0;
            st_next.gradient_threshold = grad_thr;
            st_next.timeout_left       = tmo_now;
          end
          if (turn_now) begin
            res.action        = ACT_TURN_180;
            st_next.turn_flag = !(item.angle_reached || (tmo_now == '0));
          end else if (trip_mid || trip_strong) begin
            res.action           = (diff_pos == light_mode) ? ACT_LEFT : ACT_RIGHT;
            res.diff_fraction_q8 = trip_mid ? FRAC_LOW : FRAC_HIGH;
          end else begin
            res.action = ACT_FORWARD;
          end
        end
        default: begin
          // unused modes change nothing
        end
      endcase
    end
    res.turning = st_next.turn_flag;
  end

endmodule

// File: design/light_seek_steering_core.sv
// light seek steering core: top level with stream ports, config registers,
// steering state and the result register with its skid stage; uses lss_pkg, lss_step
//
// The core takes one transaction per clock while s_tready is high, gives one result
// per transaction, in order, via the result register. Each carries a mode in s_tuser:
// sample stores the left/right lux difference, their mean and two difference
// thresholds; gradient tick shifts the mean history and forms the gradient and its
// threshold; millisecond tick counts the turn timeout down; decide returns the drive
// action (turn 180 on a favorable gradient until the angle is reached or the timeout
// ends, else a left or right differential turn, else forward); reset gradient clears
// the history and the turn flag. Percentages are q0.16 and thresholds are
// (value * pct) >> 16. All work for a transaction sits between the steering state
// registers and the result register: two sums, three 17x16 multiplies and a few
// compares, so the rate is one transaction per cycle while s_tready is high.
// A one-entry skid stage behind the result register keeps s_tready high while the
// result register waits on m_tready; s_tready drops only once both hold a result.
// Config writes are taken on any cycle with cfg_we and must be made while the core
// is idle; indexes past the last register are ignored.
module light_seek_steering_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write port
  input  logic                                  cfg_we,
  input  logic [lss_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [lss_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [16:0] lux_left, [33:17] lux_right, [34] dark_mode, [35] angle_reached
  input  logic [lss_pkg::S_TDATA_BITS-1:0]      s_tdata,
  // [2:0] mode
  input  logic [lss_pkg::S_TUSER_BITS-1:0]      s_tuser,
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [2:0] action, [10:3] diff_fraction_q8, [11] turning
  output logic [lss_pkg::M_TDATA_BITS-1:0]      m_tdata
);
  import lss_pkg::*;

  lss_cfg_t    cfg;
  lss_item_t   item;
  lss_state_t  st;
  lss_state_t  st_next;
  lss_result_t res;
  lss_result_t out_res;
  lss_result_t skid_res;
  logic        out_valid;
  logic        skid_valid;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_valid && m_tready;

  // unpack the incoming transaction
  assign item.mode          = s_tuser[2:0];
  assign item.lux_left      = s_tdata[LUX_BITS-1:0];
  assign item.lux_right     = s_tdata[2*LUX_BITS-1:LUX_BITS];
  assign item.dark_mode     = s_tdata[2*LUX_BITS];
  assign item.angle_reached = s_tdata[2*LUX_BITS+1];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b1;
      cfg.mid_pct      <= 16'd6554;
      cfg.strong_pct   <= 16'd13107;
      cfg.gradient_pct <= 16'd3277;
      cfg.timeout_ms   <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_MID_PCT:      cfg.mid_pct      <= cfg_data[PCT_BITS-1:0];
        REG_STRONG_PCT:   cfg.strong_pct   <= cfg_data[PCT_BITS-1:0];
        REG_GRADIENT_PCT: cfg.gradient_pct <= cfg_data[PCT_BITS-1:0];
        REG_TIMEOUT_MS:   cfg.timeout_ms   <= cfg_data[15:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // per-transaction logic
  lss_step u_step (
    .cfg     (cfg),
    .item    (item),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // steering state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // result register plus skid stage; ready only depends on the skid being empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_res <= skid_res;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_res.turning, out_res.diff_fraction_q8, out_res.action};

endmodule
